[rtl/tlpq_pkg.sv]
// Package: shared types, codes and helpers of the three-level priority queue.
package tlpq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdW  = 31;
  localparam int unsigned LvlW = 2;
  localparam int unsigned OccW = 5;

  localparam logic [LvlW-1:0] LvlGeneral = 2'd0;
  localparam logic [LvlW-1:0] LvlSenior  = 2'd1;
  localparam logic [LvlW-1:0] LvlVip     = 2'd2;
  localparam logic [LvlW-1:0] LvlUnused  = 2'd3;

  typedef enum logic [0:0] {
    FuncEnq = 1'b0,
    FuncDeq = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    StEnqueued = 2'd0,
    StFull     = 2'd1,
    StServed   = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [LvlW-1:0] level;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic   enq;   // insert ent at its sorted place
    logic   deq;   // shift toward the head
    entry_t ent;
  } cell_ctrl_t;

  // Unused level code counts as senior.
  function automatic logic [LvlW-1:0] decode_level(input logic [LvlW-1:0] code);
    logic [LvlW-1:0] lvl;
    lvl = (code == LvlUnused) ? LvlSenior : code;
    return lvl;
  endfunction

endpackage

[rtl/tlpq_cell.sv]
// One storage cell of the sorted queue chain.
module tlpq_cell (
  input  logic                clk_i,
  input  tlpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,       // cell holds a live entry
  input  logic                prev_ins_i,  // neighbor toward head shifts down
  input  tlpq_pkg::entry_t    prev_i,
  input  tlpq_pkg::entry_t    next_i,
  output logic                ins_o,       // new entry lands here or closer to head
  output tlpq_pkg::entry_t    entry_o
);
  import tlpq_pkg::*;

  entry_t entry_q, entry_d;

  // Sorted by level: first free or lower-level cell is the insert point.
  assign ins_o = !occ_i || (entry_q.level < ctrl_i.ent.level);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (prev_ins_i) begin
        entry_d = prev_i;
      end else if (ins_o) begin
        entry_d = ctrl_i.ent;
      end
    end else if (ctrl_i.deq) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/three_level_priority_queue_top.sv]
// Top level: three-level stable priority queue built as a chain of cells.
// The result of an accepted input transaction is on the output register in the cycle after it.
// Throughput: one transaction per cycle unless the result channel stalls; every cell
//   compares against the new level in parallel and moves one position, so no item waits.
// Reset (rst_ni low, asynchronous): queue empty, no result pending; cell
//   contents are not cleared, only positions below the count are ever read.
module three_level_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = tlpq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [30:0] passenger_id, [32:31] passenger_level, zero pad
  input  logic [0:0]  s_axis_tuser,   // [0] func
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [30:0] served_id, [32:31] served_level,
                                      // [37:33] occupancy, zero pad
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import tlpq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------
  // Handshake: the output register frees as it is taken, so a new
  // transaction is accepted in the same cycle as the result leaves.
  // ---------------------------------------------------------------------
  logic in_fire;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Unpack the input transaction.
  func_e           func;
  logic [IdW-1:0]  in_id;
  logic [LvlW-1:0] in_lvl;

  assign func   = func_e'(s_axis_tuser[0]);
  assign in_id  = s_axis_tdata[IdW-1:0];
  assign in_lvl = decode_level(s_axis_tdata[IdW+LvlW-1:IdW]);

  // ---------------------------------------------------------------------
  // Occupancy and command decode
  // ---------------------------------------------------------------------
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  cell_ctrl_t      ctrl;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  assign ctrl.enq       = in_fire && (func == FuncEnq) && !full;
  assign ctrl.deq       = in_fire && (func == FuncDeq) && !empty;
  assign ctrl.ent.id    = in_id;
  assign ctrl.ent.level = in_lvl;

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: cell 0 is the head.
  // ---------------------------------------------------------------------
  entry_t cell_ent [QUEUE_DEPTH];
  logic   cell_ins [QUEUE_DEPTH];

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(gi);
    logic   prev_ins;
    entry_t prev_ent;
    entry_t next_ent;

    if (gi == 0) begin : g_head
      assign prev_ins = 1'b0;
      assign prev_ent = cell_ent[gi];
    end else begin : g_body
      assign prev_ins = cell_ins[gi-1];
      assign prev_ent = cell_ent[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent = cell_ent[gi];   // tail keeps stale data, now unoccupied
    end else begin : g_link
      assign next_ent = cell_ent[gi+1];
    end

    tlpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (count_q > Idx),
      .prev_ins_i (prev_ins),
      .prev_i     (prev_ent),
      .next_i     (next_ent),
      .ins_o      (cell_ins[gi]),
      .entry_o    (cell_ent[gi])
    );
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  status_e         status_d, status_q;
  logic [IdW-1:0]  sid_d, sid_q;
  logic [LvlW-1:0] slvl_d, slvl_q;
  logic [OccW-1:0] occ_d, occ_q;

  always_comb begin
    sid_d  = '0;
    slvl_d = '0;
    if (func == FuncEnq) begin
      status_d = full ? StFull : StEnqueued;
    end else if (empty) begin
      status_d = StEmpty;
    end else begin
      status_d = StServed;
      sid_d    = cell_ent[0].id;
      slvl_d   = cell_ent[0].level;
    end
  end

  // count may be narrower or wider than the occupancy field
  if (CntW >= OccW) begin : g_occ_trunc
    assign occ_d = count_d[OccW-1:0];
  end else begin : g_occ_pad
    assign occ_d = {{(OccW-CntW){1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      sid_q    <= sid_d;
      slvl_q   <= slvl_d;
      occ_q    <= occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, occ_q, slvl_q, sid_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("occupancy beyond queue depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func == FuncEnq) && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("enqueue did not add an entry");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func == FuncDeq) && empty) |=> (m_axis_tvalid && m_axis_tuser == StEmpty))
    else $error("dequeue from empty queue not reported");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func == FuncEnq) && full) |=> (count_q == DepthC && m_axis_tuser == StFull))
    else $error("enqueue into full queue not dropped");
`endif

endmodule
